FILE: rtl/cpwr_pkg.sv
// ----------------------------------------------------------------------------
// cpwr_pkg
// Shared constants, types and helpers for the card pulse width reader.
// ----------------------------------------------------------------------------
package cpwr_pkg;

    localparam int EDGES_PER_CARD = 52;
    localparam int MAX_CARDS      = 16;

    localparam int TIME_W  = 32;
    localparam int EDGE_W  = 6;
    localparam int CODE_W  = 24;
    localparam int SCALE_W = 3;
    localparam int RESP_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int PROD_W  = TIME_W + SCALE_W;
    localparam int CNT_W   = $clog2(MAX_CARDS + 1);
    localparam int IDX_W   = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;

    localparam logic [EDGE_W-1:0] FIRST_BIT_EDGE = EDGE_W'(5);
    localparam logic [EDGE_W-1:0] LAST_EDGE      = EDGE_W'(EDGES_PER_CARD - 1);

    localparam logic [CODE_W-1:0] PRESET_CARD = 24'hFE097C;

    localparam logic [SCALE_W-1:0] BLACK_SCALE_RST = 3'd3;
    localparam logic [SCALE_W-1:0] TOTAL_SCALE_RST = 3'd2;

    localparam logic REG_BLACK_SCALE = 1'b0;
    localparam logic REG_TOTAL_SCALE = 1'b1;

    localparam logic [RESP_W-1:0] RESP_INVALID = 2'd0;
    localparam logic [RESP_W-1:0] RESP_KNOWN   = 2'd1;
    localparam logic [RESP_W-1:0] RESP_NEW     = 2'd2;
    localparam logic [RESP_W-1:0] RESP_FULL    = 2'd3;

    localparam logic [3:0] NIB_BAD_A = 4'd10;
    localparam logic [3:0] NIB_BAD_B = 4'd11;
    localparam logic [3:0] NIB_BAD_D = 4'd13;

    typedef struct packed {
        logic              start;
        logic [CODE_W-1:0] code;
    } lk_req_t;

    typedef struct packed {
        logic              done;
        logic [RESP_W-1:0] response;
        logic [SLOT_W-1:0] slot;
    } lk_rsp_t;

    function automatic logic code_is_valid(input logic [CODE_W-1:0] code);
        logic       ok;
        logic [3:0] nib;
        ok = 1'b1;
        for (int n = 0; n < CODE_W / 4; n++)
        begin
            nib = code[4*n +: 4];
            case (nib) inside
                NIB_BAD_A, NIB_BAD_B, NIB_BAD_D: ok = 1'b0;
                default: ;
            endcase
        end
        return ok;
    endfunction

endpackage

FILE: rtl/cpwr_list.sv
// ----------------------------------------------------------------------------
// cpwr_list
// Card list in a synchronous RAM: linear search one entry per cycle, then
// append on a miss while room is left. Entry 0 is the fixed preset card.
// ----------------------------------------------------------------------------
module cpwr_list
(
    input  logic              clk,
    input  logic              rst_n,
    input  cpwr_pkg::lk_req_t req,
    output cpwr_pkg::lk_rsp_t rsp
);
    import cpwr_pkg::*;

    logic [CODE_W-1:0] mem [MAX_CARDS];
    logic [CODE_W-1:0] rd_data_reg;
    logic [CODE_W-1:0] code_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  addr_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              cmp_vld_reg;
    logic              busy_reg;

    logic              issue;
    logic              hit;
    logic              miss;
    logic              room;
    logic              wr_en;
    logic [CODE_W-1:0] entry;

    always_comb
    begin
        issue = busy_reg && (addr_reg < cnt_reg);
        entry = (cmp_idx_reg == '0) ? PRESET_CARD : rd_data_reg;
        hit   = busy_reg && cmp_vld_reg && (entry == code_reg);
        miss  = busy_reg && !cmp_vld_reg && (addr_reg == cnt_reg);
        room  = cnt_reg < CNT_W'(MAX_CARDS);
        wr_en = miss && room;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= code_reg;
        end
        if (issue)
        begin
            rd_data_reg <= mem[addr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            code_reg <= req.code;
        end
        if (issue)
        begin
            cmp_idx_reg <= addr_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            cnt_reg     <= CNT_W'(1);
            addr_reg    <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.start)
            begin
                busy_reg    <= 1'b1;
                addr_reg    <= '0;
                cmp_vld_reg <= 1'b0;
            end
            else if (hit || miss)
            begin
                busy_reg    <= 1'b0;
                cmp_vld_reg <= 1'b0;
                if (wr_en)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            else if (busy_reg)
            begin
                cmp_vld_reg <= issue;
                if (issue)
                begin
                    addr_reg <= addr_reg + CNT_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        rsp.done     = hit || miss;
        rsp.response = RESP_FULL;
        rsp.slot     = '0;
        if (hit)
        begin
            rsp.response = RESP_KNOWN;
            rsp.slot     = SLOT_W'(cmp_idx_reg);
        end
        else if (room)
        begin
            rsp.response = RESP_NEW;
            rsp.slot     = SLOT_W'(cnt_reg);
        end
    end

endmodule

FILE: rtl/card_pulse_width_reader.sv
// ----------------------------------------------------------------------------
// card_pulse_width_reader
// Decodes pulse widths of card edges into a 24-bit code, checks it and
// looks it up in (or adds it to) the stored card list.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake          | payload
//  s_axis    | in  | tvalid / tready    | tdata[31:0] edge_time
//  m_axis    | out | tvalid / tready    | tdata card_code, response, slot
//  cfg       | in  | cfg_valid / ready  | cfg_index, cfg_data
//
//  One edge beat per cycle while no list search runs. After the last edge of a
//  valid card the list is searched, one RAM entry per cycle, and no edge is taken.
//  The last edge of a card is held off while a result beat is still pending.
//  No clearing pass after reset; entry 0 is a fixed preset, others fill up.
// ----------------------------------------------------------------------------
module card_pulse_width_reader
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [cpwr_pkg::TIME_W-1:0]     s_axis_tdata,   // [31:0] edge_time
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,   // [23:0] card_code,
                                                            // [25:24] response,
                                                            // [29:26] slot
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [cpwr_pkg::SCALE_W-1:0]    cfg_data
);
    import cpwr_pkg::*;

    localparam logic ST_EDGE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    logic               state_reg;
    logic [EDGE_W-1:0]  edge_cnt_reg;
    logic [TIME_W-1:0]  start_time_reg;
    logic [TIME_W-1:0]  black_end_reg;
    logic [CODE_W-1:0]  shift_reg;
    logic [SCALE_W-1:0] black_scale_reg;
    logic [SCALE_W-1:0] total_scale_reg;
    logic               out_valid_reg;
    logic [CODE_W-1:0]  out_code_reg;
    logic [RESP_W-1:0]  out_resp_reg;
    logic [SLOT_W-1:0]  out_slot_reg;

    logic [TIME_W-1:0]  black;
    logic [TIME_W-1:0]  total;
    logic [PROD_W-1:0]  black_prod;
    logic [PROD_W-1:0]  total_prod;
    logic               take_bit;
    logic [CODE_W-1:0]  shift_next;
    logic               last_edge;
    logic               in_acc;
    logic               card_done;
    logic               card_ok;
    lk_req_t            lk_req;
    lk_rsp_t            lk_rsp;

    always_comb
    begin
        black      = black_end_reg - start_time_reg;
        total      = s_axis_tdata - start_time_reg;
        black_prod = PROD_W'(black) * PROD_W'(black_scale_reg);
        total_prod = PROD_W'(total) * PROD_W'(total_scale_reg);
        take_bit   = edge_cnt_reg[0] && (edge_cnt_reg >= FIRST_BIT_EDGE);
        shift_next = take_bit ? {shift_reg[CODE_W-2:0], !(black_prod > total_prod)}
                              : shift_reg;
        last_edge  = edge_cnt_reg == LAST_EDGE;
        s_axis_tready = (state_reg == ST_EDGE) && (!last_edge || !out_valid_reg);
        in_acc     = s_axis_tvalid && s_axis_tready;
        card_done  = in_acc && last_edge;
        card_ok    = code_is_valid(shift_next);
        lk_req.start = card_done && card_ok;
        lk_req.code  = shift_next;
    end

    cpwr_list u_list
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lk_req),
        .rsp   (lk_rsp)
    );

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_slot_reg, out_resp_reg, out_code_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_scale_reg <= BLACK_SCALE_RST;
            total_scale_reg <= TOTAL_SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BLACK_SCALE: black_scale_reg <= cfg_data;
                REG_TOTAL_SCALE: total_scale_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_EDGE;
            edge_cnt_reg   <= '0;
            start_time_reg <= '0;
            black_end_reg  <= '0;
            shift_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                if (edge_cnt_reg[0])
                begin
                    start_time_reg <= s_axis_tdata;
                end
                else
                begin
                    black_end_reg <= s_axis_tdata;
                end
                if (last_edge)
                begin
                    edge_cnt_reg <= '0;
                    shift_reg    <= '0;
                end
                else
                begin
                    edge_cnt_reg <= edge_cnt_reg + EDGE_W'(1);
                    shift_reg    <= shift_next;
                end
            end

            unique case (state_reg)
                ST_EDGE:
                begin
                    if (card_done && card_ok)
                    begin
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (lk_rsp.done)
                    begin
                        state_reg <= ST_EDGE;
                    end
                end
            endcase

            if ((card_done && !card_ok) || lk_rsp.done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (card_done)
        begin
            out_code_reg <= shift_next;
            out_resp_reg <= RESP_INVALID;
            out_slot_reg <= '0;
        end
        else if (lk_rsp.done)
        begin
            out_resp_reg <= lk_rsp.response;
            out_slot_reg <= lk_rsp.slot;
        end
    end

    a_no_result_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> !m_axis_tvalid)
        else $error("result pending during list search");

    a_hold_last_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && last_edge) |-> !s_axis_tready)
        else $error("last edge taken while result pending");

    a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        lk_rsp.done |-> (state_reg == ST_SEARCH))
        else $error("list done outside search");

    a_card_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        card_done |=> (edge_cnt_reg == '0 && shift_reg == '0))
        else $error("edge state not cleared after card");

endmodule

FILE: test/card_pulse_width_reader_tb.sv
// ----------------------------------------------------------------------------
// card_pulse_width_reader_tb
// Streams whole cards of edge timestamps into the reader. Each card is shaped
// for a chosen code, built from random noise, or made of falling timestamps.
// Cards are sent under several scale settings, the extremes among them.
// A scoreboard decodes every accepted edge itself, keeps its own card list,
// and checks each result beat field by field. Both stream sides idle at
// random. The result side also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module card_pulse_width_reader_tb;
    import cpwr_pkg::*;

    localparam int          HOLD_CYCLES  = 600;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          DRAIN_CYCLES = 50;
    localparam int          NUM_PHASES   = 8;
    localparam int          PHASE_CARDS  = 4;
    localparam int unsigned SHORT_SPAN   = 4096;
    localparam int unsigned LONG_SPAN    = 32'h1000_0000;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [RESP_W-1:0] response;
        logic [SLOT_W-1:0] slot;
    } card_result_t;

    typedef enum int {CARD_TARGET, CARD_NOISE, CARD_DESCEND} card_kind_t;

    class card_scoreboard;
        logic [SCALE_W-1:0] black_scale;
        logic [SCALE_W-1:0] total_scale;
        logic [EDGE_W-1:0]  edge_cnt;
        logic [TIME_W-1:0]  bit_start;
        logic [TIME_W-1:0]  black_end;
        logic [CODE_W-1:0]  code_shift;
        logic [CODE_W-1:0]  known_cards[MAX_CARDS];
        int                 known_count;
        card_result_t       expected_q[$];
        int                 errors;

        function new();
            black_scale    = BLACK_SCALE_RST;
            total_scale    = TOTAL_SCALE_RST;
            edge_cnt       = '0;
            bit_start      = '0;
            black_end      = '0;
            code_shift     = '0;
            known_cards[0] = PRESET_CARD;
            known_count    = 1;
            errors         = 0;
        endfunction

        function void note_config(logic idx, logic [SCALE_W-1:0] value);
            if (idx == REG_BLACK_SCALE)
                black_scale = value;
            else
                total_scale = value;
        endfunction

        function bit chars_ok(logic [CODE_W-1:0] code);
            logic [3:0] ch;
            for (int n = 0; n < CODE_W / 4; n++)
            begin
                ch = code[4*n +: 4];
                if (ch == NIB_BAD_A || ch == NIB_BAD_B || ch == NIB_BAD_D)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_edge(logic [TIME_W-1:0] t);
            logic [TIME_W-1:0] black_d;
            logic [TIME_W-1:0] total_d;
            longint unsigned   black_p;
            longint unsigned   total_p;
            card_result_t      r;
            if (edge_cnt[0] && edge_cnt >= FIRST_BIT_EDGE)
            begin
                black_d    = black_end - bit_start;
                total_d    = t - bit_start;
                black_p    = 64'(black_d) * 64'(black_scale);
                total_p    = 64'(total_d) * 64'(total_scale);
                code_shift = {code_shift[CODE_W-2:0], (black_p > total_p) ? 1'b0 : 1'b1};
            end
            if (edge_cnt[0])
                bit_start = t;
            else
                black_end = t;
            if (edge_cnt != LAST_EDGE)
            begin
                edge_cnt++;
                return;
            end
            r.code     = code_shift;
            r.response = RESP_INVALID;
            r.slot     = '0;
            edge_cnt   = '0;
            code_shift = '0;
            if (chars_ok(r.code))
            begin
                r.response = RESP_FULL;
                for (int i = 0; i < known_count; i++)
                begin
                    if (known_cards[i] == r.code)
                    begin
                        r.response = RESP_KNOWN;
                        r.slot     = SLOT_W'(i);
                        break;
                    end
                end
                if (r.response == RESP_FULL && known_count < MAX_CARDS)
                begin
                    known_cards[known_count] = r.code;
                    r.slot     = SLOT_W'(known_count);
                    r.response = RESP_NEW;
                    known_count++;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [31:0] beat);
            card_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("result beat %h with no card pending", beat);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (beat[23:0] != e.code)
            begin
                $error("card_code: expected %h, got %h", e.code, beat[23:0]);
                errors++;
            end
            if (beat[25:24] != e.response)
            begin
                $error("response: expected %0d, got %0d", e.response, beat[25:24]);
                errors++;
            end
            if (beat[29:26] != e.slot)
            begin
                $error("slot: expected %0d, got %0d", e.slot, beat[29:26]);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TIME_W-1:0]   s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [31:0]         m_axis_tdata;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic                cfg_index     = REG_BLACK_SCALE;
    logic [SCALE_W-1:0]  cfg_data      = '0;

    card_scoreboard sb;
    int             tx_max   = 18;
    int             rx_max   = 18;
    bit             hold_req = 1'b0;
    int             idle_cycles = 0;

    logic [SCALE_W-1:0] black_set[NUM_PHASES] = '{3'd7, 3'd1, 3'd0, 3'd4, 3'd7, 3'd1, 3'd5, 3'd2};
    logic [SCALE_W-1:0] total_set[NUM_PHASES] = '{3'd1, 3'd7, 3'd5, 3'd0, 3'd7, 3'd1, 3'd3, 3'd6};

    card_pulse_width_reader dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("card_pulse_width_reader: mismatch");
            $finish;
        end
    end

    task automatic send_edge(input logic [TIME_W-1:0] t);
        int gap;
        gap = (tx_max > 0) ? $urandom_range(0, tx_max) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_edge(t);
    endtask

    // black width that lands the bit on the wanted side under current scales
    function automatic logic [TIME_W-1:0] black_for(logic value, logic [TIME_W-1:0] total);
        longint unsigned lim;
        if (sb.black_scale == 0)
            return $urandom_range(0, total);
        lim = (64'(total) * 64'(sb.total_scale)) / 64'(sb.black_scale);
        if (value)
            return $urandom_range(0, TIME_W'(lim));
        return TIME_W'(lim + 64'(1) + 64'($urandom_range(0, total)));
    endfunction

    function automatic logic [CODE_W-1:0] fresh_code();
        logic [CODE_W-1:0] c;
        logic [3:0]        ch;
        for (int n = 0; n < CODE_W / 4; n++)
        begin
            do
                ch = 4'($urandom_range(0, 15));
            while (ch == NIB_BAD_A || ch == NIB_BAD_B || ch == NIB_BAD_D);
            c[4*n +: 4] = ch;
        end
        return c;
    endfunction

    task automatic send_card(input card_kind_t kind, input logic [CODE_W-1:0] code,
                             input int unsigned span);
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] total;
        t = $urandom();
        case (kind)
            CARD_NOISE:
                for (int k = 0; k < EDGES_PER_CARD; k++)
                    send_edge($urandom());
            CARD_DESCEND:
                for (int k = 0; k < EDGES_PER_CARD; k++)
                    send_edge(t - TIME_W'(k));
            default:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if (k > 0)
                        t += $urandom_range(1, span);
                    send_edge(t);
                end
                for (int i = 0; i < (EDGES_PER_CARD - 4) / 2; i++)
                begin
                    total = $urandom_range(1, span);
                    send_edge(t + black_for(code[CODE_W-1-i], total));
                    t += total;
                    send_edge(t);
                end
            end
        endcase
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [SCALE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.note_config(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : result_sink
        int gap;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = (rx_max > 0) ? $urandom_range(0, rx_max) : 0;
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            sb.check_result(m_axis_tdata);
        end
    end

    initial
    begin : edge_source
        int          pick;
        int unsigned span;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_write(REG_BLACK_SCALE, BLACK_SCALE_RST);
        cfg_write(REG_TOTAL_SCALE, TOTAL_SCALE_RST);
        // preset card, two with bad characters, falling stamps, then code zero with long spans
        send_card(CARD_TARGET, PRESET_CARD, SHORT_SPAN);
        send_card(CARD_TARGET, 24'h12A456, SHORT_SPAN);
        send_card(CARD_TARGET, 24'h9D0B73, LONG_SPAN);
        send_card(CARD_DESCEND, '0, SHORT_SPAN);
        send_card(CARD_TARGET, '0, LONG_SPAN);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            cfg_write(REG_BLACK_SCALE, black_set[p]);
            cfg_write(REG_TOTAL_SCALE, total_set[p]);
            tx_max = (p % 3 == 1) ? 0 : 18;
            rx_max = (p % 3 == 2) ? 0 : 18;
            for (int c = 0; c < PHASE_CARDS; c++)
            begin
                if (p == 1 && c == 1)
                    hold_req = 1'b1;
                pick = $urandom_range(0, 9);
                span = ($urandom_range(0, 7) == 0) ? LONG_SPAN : SHORT_SPAN;
                if (pick < 2)
                    send_card(CARD_NOISE, '0, span);
                else if (pick < 5)
                    send_card(CARD_TARGET,
                              sb.known_cards[$urandom_range(0, sb.known_count - 1)], span);
                else if (pick < 9)
                    send_card(CARD_TARGET, fresh_code(), span);
                else
                    send_card(CARD_TARGET, CODE_W'($urandom()), span);
                if ($urandom_range(0, 5) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("card_pulse_width_reader: match");
        else
            $display("card_pulse_width_reader: mismatch");
        $finish;
    end

endmodule
